/* rtl/tesd_pkg.sv */
// ----------------------------------------------------------------------------
// tesd_pkg
// Shared types and constants for the three-electrode swipe detector.
// ----------------------------------------------------------------------------
package tesd_pkg;

  // Electrode codes.
  localparam logic [1:0] ElecFirst   = 2'd0;
  localparam logic [1:0] ElecMid     = 2'd1;
  localparam logic [1:0] ElecLast    = 2'd2;
  localparam logic [1:0] ElecInvalid = 2'd3;

  // Progress codes: touches held in the partial swipe.
  localparam logic [1:0] ProgIdle = 2'd0;
  localparam logic [1:0] ProgOne  = 2'd1;
  localparam logic [1:0] ProgTwo  = 2'd2;

  // Timeout value after reset, in ms.
  localparam logic [31:0] TimeoutReset = 32'd500;

  // Stream widths: fields packed from bit 0, padded to whole bytes.
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 72;

  // One touch item.
  typedef struct packed {
    logic [31:0] time_ms;
    logic [1:0]  electrode;
  } touch_t;

  // One result item.
  typedef struct packed {
    logic [31:0] second_gap_ms;
    logic [31:0] first_gap_ms;
    logic        reverse;
    logic        detected;
  } result_t;

endpackage

/* rtl/tesd_in_stage.sv */
// ----------------------------------------------------------------------------
// tesd_in_stage
// Input register: captures one touch item from the stream and holds it until
// the tracker consumes it.
// ----------------------------------------------------------------------------
module tesd_in_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tesd_pkg::InTdataW-1:0]     in_tdata,
  input  logic                              advance,
  output logic                              item_valid,
  output tesd_pkg::touch_t                  item
);
  import tesd_pkg::*;

  logic   valid_r, valid_nxt;
  touch_t item_r, item_nxt;

  // The register can take a new item when empty or when its item moves on.
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      item_nxt.electrode = in_tdata[1:0];
      item_nxt.time_ms   = in_tdata[33:2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* rtl/tesd_track.sv */
// ----------------------------------------------------------------------------
// tesd_track
// Swipe tracking state, timeout register and the single-pass next-state and
// result logic for one touch item.
// ----------------------------------------------------------------------------
module tesd_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              advance,
  input  tesd_pkg::touch_t  item,
  output tesd_pkg::result_t result
);
  import tesd_pkg::*;

  logic [31:0] timeout_r;
  logic [1:0]  progress_r, progress_nxt;
  logic [1:0]  seen_e0_r, seen_e0_nxt;
  logic [1:0]  seen_e1_r, seen_e1_nxt;
  logic [31:0] seen_t0_r, seen_t0_nxt;
  logic [31:0] seen_t1_r, seen_t1_nxt;

  logic [31:0] age;
  logic [1:0]  prog_eff;
  logic        have_two;
  logic [1:0]  last_e;
  logic        expected;
  logic        is_end;

  // Age of the swipe start, modulo 2^32, and the timeout drop.
  assign age      = item.time_ms - seen_t0_r;
  assign prog_eff = ((progress_r != ProgIdle) && (age > timeout_r)) ? ProgIdle : progress_r;
  assign have_two = (prog_eff >= ProgTwo);
  assign last_e   = have_two ? seen_e1_r : seen_e0_r;
  assign is_end   = (item.electrode == ElecFirst) || (item.electrode == ElecLast);

  always_comb begin
    if (have_two) begin
      expected = (seen_e0_r == ElecFirst) ? (item.electrode == ElecLast)
                                          : (item.electrode == ElecFirst);
    end else begin
      expected = (item.electrode == ElecMid);
    end
  end

  // Next state and result for the current item.
  always_comb begin
    progress_nxt = prog_eff;
    seen_e0_nxt  = seen_e0_r;
    seen_e1_nxt  = seen_e1_r;
    seen_t0_nxt  = seen_t0_r;
    seen_t1_nxt  = seen_t1_r;
    result       = '0;
    if (item.electrode == ElecInvalid) begin
      progress_nxt = prog_eff;
    end else if (prog_eff == ProgIdle || (item.electrode != last_e && !expected)) begin
      // Start a new swipe at an end electrode, otherwise clear.
      if (is_end) begin
        seen_e0_nxt  = item.electrode;
        seen_t0_nxt  = item.time_ms;
        progress_nxt = ProgOne;
      end else begin
        progress_nxt = ProgIdle;
      end
    end else if (item.electrode == last_e) begin
      // A repeat touch of the last electrode changes nothing.
      progress_nxt = prog_eff;
    end else if (!have_two) begin
      seen_e1_nxt  = item.electrode;
      seen_t1_nxt  = item.time_ms;
      progress_nxt = ProgTwo;
    end else begin
      result.detected      = 1'b1;
      result.reverse       = (seen_e0_r != ElecFirst);
      result.first_gap_ms  = seen_t1_r - seen_t0_r;
      result.second_gap_ms = item.time_ms - seen_t1_r;
      progress_nxt         = ProgIdle;
    end
  end

  // Timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Progress is control state; the held touches are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r <= ProgIdle;
    end else if (advance) begin
      progress_r <= progress_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seen_e0_r <= seen_e0_nxt;
      seen_e1_r <= seen_e1_nxt;
      seen_t0_r <= seen_t0_nxt;
      seen_t1_r <= seen_t1_nxt;
    end
  end

endmodule

/* rtl/tesd_out_stage.sv */
// ----------------------------------------------------------------------------
// tesd_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module tesd_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  tesd_pkg::result_t              result,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tesd_pkg::OutTdataW-1:0] out_tdata
);
  import tesd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // Load on advance, drop once taken.
  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(OutTdataW - $bits(result_t))'(0), data_r};

endmodule

/* rtl/three_electrode_swipe_detector.sv */
// ----------------------------------------------------------------------------
// three_electrode_swipe_detector
// Detects 0-1-2 and 2-1-0 touch runs over three electrodes in a row.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries touch items: electrode and a millisecond timestamp.
//   Every accepted item yields exactly one item on the out_ stream, with
//   detected set when the touch completes a swipe, the direction and the two
//   gaps between touches; all fields are zero otherwise.
//   cfg_we writes timeout_ms from cfg_wdata; write it only while the block
//   holds no item.
//   out_tvalid rises after acceptance once the item has passed the input
//   register and the tracking logic has loaded the result register.
//   Throughput is one item per cycle while out_tready stays high, set by the
//   per-item state update in the tracker.
//   Reset (rst_n low, synchronous) empties both registers, clears the swipe
//   progress and loads timeout_ms with 500.
//   While out_tready is low the result waits in its register; one more item
//   is still taken into the input register, then in_tready drops until the
//   result is taken.
// ----------------------------------------------------------------------------
module three_electrode_swipe_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  // Touch items.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tesd_pkg::InTdataW-1:0]  in_tdata,   // electrode[1:0], time_ms[33:2], zero pad
  // Result items.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tesd_pkg::OutTdataW-1:0] out_tdata,  // detected[0], reverse[1],
                                                     // first_gap_ms[33:2],
                                                     // second_gap_ms[65:34], zero pad
  // Timeout register.
  input  logic                           cfg_we,
  input  logic [31:0]                    cfg_wdata
);
  import tesd_pkg::*;

  logic    item_valid;
  touch_t  item;
  result_t result;
  logic    advance;

  // An item moves to the result register when that register is free.
  assign advance = item_valid && (!out_tvalid || out_tready);

  tesd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tesd_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  tesd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .result     (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/tesd_checker.sv */
// ----------------------------------------------------------------------------
// tesd_checker
// Port-level checks for the swipe detector, bound to the top level.
// ----------------------------------------------------------------------------
module tesd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tesd_pkg::OutTdataW-1:0] out_tdata
);
  import tesd_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A result that is not a swipe carries all-zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OutTdataW-1:1] == '0)
    else $error("non-detect result has nonzero fields");

  // Pad bits above the last field stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutTdataW-1:66] == '0)
    else $error("result pad bits nonzero");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A rising result valid needs an accepted item that has passed the input register.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without an accepted item");

endmodule

bind three_electrode_swipe_detector tesd_checker u_tesd_checker (.*);

/* bench/swipe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swipe_checker
// Watches the touch, result and timeout ports of the swipe detector, keeps
// its own copy of the swipe tracking state, and compares every result item
// field by field with the one predicted for the oldest outstanding touch.
// ----------------------------------------------------------------------------
module swipe_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [tesd_pkg::InTdataW-1:0]  in_tdata,   // electrode[1:0], time_ms[33:2], zero pad
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [tesd_pkg::OutTdataW-1:0] out_tdata,  // detected[0], reverse[1],
                                                     // first_gap_ms[33:2],
                                                     // second_gap_ms[65:34], zero pad
  input  logic                           cfg_we,
  input  logic [31:0]                    cfg_wdata,
  output int                             fail_count,
  output int                             outstanding
);
  import tesd_pkg::*;

  // Tracking state mirrored from the detector.
  logic [31:0] timeout_q;
  logic [1:0]  prog;
  logic [1:0]  held_elec [2];
  logic [31:0] held_time [2];

  // Results predicted for accepted touches, oldest first.
  result_t expected_results [$];
  result_t want;
  result_t got;

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
             $realtime, what, seen, wanted);
    fail_count++;
  endtask

  // Start a new partial swipe if the touch is at an end, else drop it.
  task automatic begin_swipe(input touch_t tch);
    if (tch.electrode == ElecFirst || tch.electrode == ElecLast) begin
      held_elec[0] = tch.electrode;
      held_time[0] = tch.time_ms;
      prog = ProgOne;
    end else begin
      prog = ProgIdle;
    end
  endtask

  // Advance the swipe state by one touch and give the result it causes.
  task automatic track_touch(input touch_t tch, output result_t res);
    int     last;
    logic   in_seq;
    res = '0;
    // An aged partial swipe is dropped first, whatever the electrode.
    if (prog != ProgIdle && (tch.time_ms - held_time[0]) > timeout_q)
      prog = ProgIdle;
    if (tch.electrode == ElecInvalid)
      return;
    if (prog == ProgIdle) begin
      begin_swipe(tch);
      return;
    end
    last = (prog == ProgOne) ? 0 : 1;
    // A repeat touch of the last electrode changes nothing.
    if (tch.electrode == held_elec[last])
      return;
    if (prog == ProgOne)
      in_seq = (tch.electrode == ElecMid);
    else if (held_elec[0] == ElecFirst)
      in_seq = (tch.electrode == ElecLast);
    else
      in_seq = (tch.electrode == ElecFirst);
    if (!in_seq) begin
      begin_swipe(tch);
      return;
    end
    if (prog == ProgOne) begin
      held_elec[1] = tch.electrode;
      held_time[1] = tch.time_ms;
      prog = ProgTwo;
      return;
    end
    // Third touch in order completes the swipe.
    res.detected      = 1'b1;
    res.reverse       = (held_elec[0] != ElecFirst);
    res.first_gap_ms  = held_time[1] - held_time[0];
    res.second_gap_ms = tch.time_ms - held_time[1];
    prog = ProgIdle;
  endtask

  // Sample all ports at the clock edge; config goes first so that a touch
  // taken at the same edge sees the new timeout.
  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_q = TimeoutReset;
      prog = ProgIdle;
      held_elec[0] = '0;
      held_elec[1] = '0;
      held_time[0] = '0;
      held_time[1] = '0;
      expected_results.delete();
    end else begin
      if (cfg_we)
        timeout_q = cfg_wdata;
      if (in_tvalid && in_tready) begin
        track_touch(touch_t'(in_tdata[$bits(touch_t)-1:0]), want);
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", 32'(got.detected), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.detected != want.detected)
            report_mismatch("detected", 32'(got.detected), 32'(want.detected));
          if (got.reverse != want.reverse)
            report_mismatch("reverse", 32'(got.reverse), 32'(want.reverse));
          if (got.first_gap_ms != want.first_gap_ms)
            report_mismatch("first_gap_ms", got.first_gap_ms, want.first_gap_ms);
          if (got.second_gap_ms != want.second_gap_ms)
            report_mismatch("second_gap_ms", got.second_gap_ms, want.second_gap_ms);
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

/* bench/three_electrode_swipe_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_electrode_swipe_detector_tb
// Drives directed and random touch streams into the swipe detector under
// several timeout settings, with random gaps and output stalls, and lets
// the checker compare every result item against its own prediction.
// ----------------------------------------------------------------------------
module three_electrode_swipe_detector_tb;
  import tesd_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int PhaseItems   = 100;
  localparam int SettleCycles = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata = '0;   // electrode[1:0], time_ms[33:2], zero pad
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;       // detected[0], reverse[1],
                                         // first_gap_ms[33:2],
                                         // second_gap_ms[65:34], zero pad
  logic                 cfg_we = 1'b0;
  logic [31:0]          cfg_wdata = '0;

  int          fail_count;
  int          outstanding;
  int          sent_count;
  int          rx_wait;
  int          rx_draw;
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  logic [31:0] now_ms = '0;
  logic [31:0] timeout_cur = TimeoutReset;

  three_electrode_swipe_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  swipe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: after each taken item, stall for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (out_tready && out_tvalid) begin
      if ($urandom_range(0, 31) == 0)
        rx_steady = !rx_steady;
      rx_draw = rx_steady ? 0 : int'($urandom_range(0, 5));
      rx_wait <= rx_draw;
      out_tready <= (rx_draw == 0);
    end else if (!out_tready) begin
      if (rx_wait <= 1) begin
        out_tready <= 1'b1;
        rx_wait <= 0;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  // Present one touch item after a random gap and wait until it is taken.
  task automatic send_touch(input logic [1:0] elec, input logic [31:0] t_ms);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(InTdataW - 34){1'b0}}, t_ms, elec};
    do @(posedge clk); while (!in_tready);
    if (elec != ElecInvalid)
      sent_count++;
  endtask

  // Time step between touches, mostly inside the timeout, sometimes past it.
  function automatic logic [31:0] draw_step();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 6)
      return $urandom_range(0, timeout_cur / 3);
    else if (pick == 7)
      return timeout_cur + $urandom_range(0, 2);
    else if (pick == 8)
      return $urandom;
    else
      return '0;
  endfunction

  // Touch an electrode at the next time, now and then followed by a repeat.
  task automatic timed_touch(input logic [1:0] elec);
    now_ms = now_ms + draw_step();
    send_touch(elec, now_ms);
    if ($urandom_range(0, 4) == 0) begin
      now_ms = now_ms + draw_step();
      send_touch(elec, now_ms);
    end
  endtask

  // A full forward or reverse run with random timing.
  task automatic swipe_sequence();
    logic [1:0] start_elec;
    start_elec = $urandom_range(0, 1) ? ElecLast : ElecFirst;
    tx_steady = ($urandom_range(0, 3) == 0);
    timed_touch(start_elec);
    timed_touch(ElecMid);
    timed_touch(ElecLast - start_elec);
  endtask

  // A stray touch: any electrode, near the current time or anywhere.
  task automatic noise_touch();
    if ($urandom_range(0, 1))
      now_ms = now_ms + draw_step();
    else
      now_ms = $urandom;
    send_touch(2'($urandom_range(0, 3)), now_ms);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the timeout register while the detector is empty.
  task automatic write_timeout(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_cur = value;
  endtask

  // Watchdog on the whole run.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [31:0] phase_timeout [5];
    phase_timeout[0] = 32'd0;
    phase_timeout[1] = 32'hFFFF_FFFF;
    phase_timeout[2] = $urandom_range(1, 2000);
    phase_timeout[3] = $urandom;
    phase_timeout[4] = TimeoutReset;
    sent_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed touches under the reset timeout of 500 ms.
    send_touch(ElecMid, 32'd10);              // middle touch while idle
    send_touch(ElecInvalid, 32'd20);          // invalid electrode
    send_touch(ElecFirst, 32'd0);
    send_touch(ElecFirst, 32'd5);             // repeat of the start
    send_touch(ElecMid, 32'd100);
    send_touch(ElecMid, 32'd120);             // repeat of the middle
    send_touch(ElecLast, 32'd300);            // forward swipe
    send_touch(ElecLast, 32'd1000);
    send_touch(ElecMid, 32'd1200);
    send_touch(ElecFirst, 32'd1499);          // reverse swipe just in time
    send_touch(ElecFirst, 32'd2000);
    send_touch(ElecLast, 32'd2100);           // out of order, restarts at 2
    send_touch(ElecMid, 32'd2200);
    send_touch(ElecLast, 32'd2300);           // out of order after two touches
    send_touch(ElecInvalid, 32'd2801);        // invalid touch still times out
    send_touch(ElecMid, 32'd2802);            // swipe is gone, ignored
    send_touch(ElecFirst, 32'hFFFF_FF00);
    send_touch(ElecMid, 32'hFFFF_FFFF);
    send_touch(ElecLast, 32'h0000_00F4);      // wraps, age equal to timeout
    send_touch(ElecLast, 32'h0000_0100);
    send_touch(ElecMid, 32'h0000_02F5);       // one past the timeout
    send_touch(ElecFirst, 32'hFFFF_FFFF);
    send_touch(ElecInvalid, 32'hFFFF_FFFF);
    drain_results();

    // Random phases, each under its own timeout setting.
    for (int ph = 0; ph < 5; ph++) begin
      write_timeout(phase_timeout[ph]);
      now_ms = $urandom;
      sent_count = 0;
      while (sent_count < PhaseItems) begin
        if ($urandom_range(0, 9) < 7)
          swipe_sequence();
        else
          noise_touch();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
